FILE: rtl/lcd_timing_stat_controller_core_defines.svh
// Assertion macros shared by the display timing controller RTL.
`ifndef LCD_TIMING_STAT_CONTROLLER_CORE_DEFINES_SVH
`define LCD_TIMING_STAT_CONTROLLER_CORE_DEFINES_SVH

// invariant checked at every clock edge outside reset
`define LCD_TSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define LCD_TSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lcd_tsc_pkg.sv
// Types and constants of the display timing controller.
package lcd_tsc_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_DRAW   = 2'd3
   } lcd_mode_type;

   localparam logic [9:0] DOTS_OAM    = 10'd80;
   localparam logic [9:0] DOTS_DRAW   = 10'd172;
   localparam logic [9:0] DOTS_HBLANK = 10'd204;
   localparam logic [9:0] DOTS_LINE   = 10'd456;
   localparam logic [7:0] LY_VBLANK   = 8'd144;
   localparam logic [7:0] LY_LAST     = 8'd153;

   localparam logic [15:0] ADDR_LCDC = 16'hFF40;
   localparam logic [15:0] ADDR_STAT = 16'hFF41;
   localparam logic [15:0] ADDR_SCY  = 16'hFF42;
   localparam logic [15:0] ADDR_SCX  = 16'hFF43;
   localparam logic [15:0] ADDR_LY   = 16'hFF44;
   localparam logic [15:0] ADDR_LYC  = 16'hFF45;
   localparam logic [15:0] ADDR_DMA  = 16'hFF46;
   localparam logic [15:0] ADDR_BGP  = 16'hFF47;
   localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
   localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
   localparam logic [15:0] ADDR_WY   = 16'hFF4A;
   localparam logic [15:0] ADDR_WX   = 16'hFF4B;

   localparam logic [7:0] READ_UNMAPPED = 8'hFF;

   typedef struct packed {
      cmd_type     cmd;
      logic [6:0]  dot_count;
      logic [15:0] reg_address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic       frame_done;
      logic       line_done;
      logic       stat_irq;
      logic       vblank_irq;
      logic [7:0] read_data;
   } rsp_type;

endpackage

FILE: rtl/lcd_tsc_timing.sv
// Dot counter, mode sequencer, STAT interrupt edge logic and register file.
`include "lcd_timing_stat_controller_core_defines.svh"

module lcd_tsc_timing (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  lcd_tsc_pkg::req_type req,
   output lcd_tsc_pkg::rsp_type rsp
);

   logic [7:0]                lcdc_ff, lcdc_in;
   logic [3:0]                stat_en_ff, stat_en_in;
   logic                      lyc_match_ff, lyc_match_in;
   lcd_tsc_pkg::lcd_mode_type mode_ff, mode_in;
   logic [7:0]                scy_ff, scy_in;
   logic [7:0]                scx_ff, scx_in;
   logic [7:0]                ly_ff, ly_in;
   logic [7:0]                lyc_ff, lyc_in;
   logic [7:0]                dma_ff, dma_in;
   logic [7:0]                bgp_ff, bgp_in;
   logic [7:0]                obp0_ff, obp0_in;
   logic [7:0]                obp1_ff, obp1_in;
   logic [7:0]                wy_ff, wy_in;
   logic [7:0]                wx_ff, wx_in;
   logic [9:0]                dot_ff, dot_in;
   logic                      latch_ff, latch_in;

   logic [9:0]                dot_sum;
   logic [9:0]                step_thr;
   logic                      step_taken;
   logic [9:0]                dot_step;
   logic [7:0]                ly_inc;
   logic [7:0]                ly_step;
   lcd_tsc_pkg::lcd_mode_type mode_step;
   logic                      match_step;
   logic                      stat_src;
   logic                      tick_on;
   logic                      line_end;
   logic                      vblank_entry;
   logic                      stat_edge;

   // next mode, line and dot count for a tick with the display on
   always_comb begin
      dot_sum   = 10'(dot_ff + {3'b000, req.dot_count});
      ly_inc    = 8'(ly_ff + 8'd1);
      ly_step   = ly_ff;
      mode_step = mode_ff;
      unique case (mode_ff)
         lcd_tsc_pkg::MODE_OAM:    step_thr = lcd_tsc_pkg::DOTS_OAM;
         lcd_tsc_pkg::MODE_DRAW:   step_thr = lcd_tsc_pkg::DOTS_DRAW;
         lcd_tsc_pkg::MODE_HBLANK: step_thr = lcd_tsc_pkg::DOTS_HBLANK;
         default:                  step_thr = lcd_tsc_pkg::DOTS_LINE;
      endcase
      step_taken = (dot_sum >= step_thr);
      dot_step   = step_taken ? 10'(dot_sum - step_thr) : dot_sum;
      if (step_taken) begin
         unique case (mode_ff)
            lcd_tsc_pkg::MODE_OAM: begin
               mode_step = lcd_tsc_pkg::MODE_DRAW;
            end
            lcd_tsc_pkg::MODE_DRAW: begin
               mode_step = lcd_tsc_pkg::MODE_HBLANK;
            end
            lcd_tsc_pkg::MODE_HBLANK: begin
               ly_step   = ly_inc;
               mode_step = (ly_inc == lcd_tsc_pkg::LY_VBLANK) ? lcd_tsc_pkg::MODE_VBLANK
                                                             : lcd_tsc_pkg::MODE_OAM;
            end
            default: begin
               if (ly_inc > lcd_tsc_pkg::LY_LAST) begin
                  ly_step   = 8'd0;
                  mode_step = lcd_tsc_pkg::MODE_OAM;
               end else begin
                  ly_step = ly_inc;
               end
            end
         endcase
      end
      match_step = (ly_step == lyc_ff);
      stat_src   = (stat_en_ff[3] && match_step)
                || (stat_en_ff[2] && mode_step == lcd_tsc_pkg::MODE_OAM)
                || (stat_en_ff[1] && mode_step == lcd_tsc_pkg::MODE_VBLANK)
                || (stat_en_ff[0] && mode_step == lcd_tsc_pkg::MODE_HBLANK);
   end

   // pulses of a tick step
   always_comb begin
      tick_on      = (req.cmd == lcd_tsc_pkg::CMD_TICK) && lcdc_ff[7];
      line_end     = tick_on && step_taken && (mode_ff == lcd_tsc_pkg::MODE_DRAW);
      vblank_entry = tick_on && step_taken && (mode_ff == lcd_tsc_pkg::MODE_HBLANK)
                  && (ly_inc == lcd_tsc_pkg::LY_VBLANK);
      stat_edge    = tick_on && step_taken && stat_src && !latch_ff;
   end

   always_comb begin
      lcdc_in      = lcdc_ff;
      stat_en_in   = stat_en_ff;
      lyc_match_in = lyc_match_ff;
      mode_in      = mode_ff;
      scy_in       = scy_ff;
      scx_in       = scx_ff;
      ly_in        = ly_ff;
      lyc_in       = lyc_ff;
      dma_in       = dma_ff;
      bgp_in       = bgp_ff;
      obp0_in      = obp0_ff;
      obp1_in      = obp1_ff;
      wy_in        = wy_ff;
      wx_in        = wx_ff;
      dot_in       = dot_ff;
      latch_in     = latch_ff;
      unique case (req.cmd)
         lcd_tsc_pkg::CMD_TICK: begin
            if (!lcdc_ff[7]) begin
               dot_in   = 10'd0;
               ly_in    = 8'd0;
               mode_in  = lcd_tsc_pkg::MODE_HBLANK;
               latch_in = 1'b0;
            end else begin
               dot_in = dot_step;
               if (step_taken) begin
                  ly_in        = ly_step;
                  mode_in      = mode_step;
                  lyc_match_in = match_step;
                  latch_in     = stat_src;
               end
            end
         end
         lcd_tsc_pkg::CMD_WRITE: begin
            unique case (req.reg_address)
               lcd_tsc_pkg::ADDR_LCDC: begin
                  lcdc_in = req.write_data;
                  if (lcdc_ff[7] && !req.write_data[7]) begin
                     dot_in   = 10'd0;
                     ly_in    = 8'd0;
                     mode_in  = lcd_tsc_pkg::MODE_HBLANK;
                     latch_in = 1'b0;
                  end
               end
               lcd_tsc_pkg::ADDR_STAT: stat_en_in = req.write_data[6:3];
               lcd_tsc_pkg::ADDR_SCY:  scy_in     = req.write_data;
               lcd_tsc_pkg::ADDR_SCX:  scx_in     = req.write_data;
               lcd_tsc_pkg::ADDR_LYC:  lyc_in     = req.write_data;
               lcd_tsc_pkg::ADDR_DMA:  dma_in     = req.write_data;
               lcd_tsc_pkg::ADDR_BGP:  bgp_in     = req.write_data;
               lcd_tsc_pkg::ADDR_OBP0: obp0_in    = req.write_data;
               lcd_tsc_pkg::ADDR_OBP1: obp1_in    = req.write_data;
               lcd_tsc_pkg::ADDR_WY:   wy_in      = req.write_data;
               lcd_tsc_pkg::ADDR_WX:   wx_in      = req.write_data;
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp            = '0;
      rsp.vblank_irq = vblank_entry;
      rsp.frame_done = vblank_entry;
      rsp.line_done  = line_end;
      rsp.stat_irq   = stat_edge;
      if (req.cmd == lcd_tsc_pkg::CMD_READ) begin
         unique case (req.reg_address)
            lcd_tsc_pkg::ADDR_LCDC: rsp.read_data = lcdc_ff;
            lcd_tsc_pkg::ADDR_STAT: rsp.read_data = {1'b1, stat_en_ff, lyc_match_ff, mode_ff};
            lcd_tsc_pkg::ADDR_SCY:  rsp.read_data = scy_ff;
            lcd_tsc_pkg::ADDR_SCX:  rsp.read_data = scx_ff;
            lcd_tsc_pkg::ADDR_LY:   rsp.read_data = ly_ff;
            lcd_tsc_pkg::ADDR_LYC:  rsp.read_data = lyc_ff;
            lcd_tsc_pkg::ADDR_DMA:  rsp.read_data = dma_ff;
            lcd_tsc_pkg::ADDR_BGP:  rsp.read_data = bgp_ff;
            lcd_tsc_pkg::ADDR_OBP0: rsp.read_data = obp0_ff;
            lcd_tsc_pkg::ADDR_OBP1: rsp.read_data = obp1_ff;
            lcd_tsc_pkg::ADDR_WY:   rsp.read_data = wy_ff;
            lcd_tsc_pkg::ADDR_WX:   rsp.read_data = wx_ff;
            default:                rsp.read_data = lcd_tsc_pkg::READ_UNMAPPED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcdc_ff      <= '0;
         stat_en_ff   <= '0;
         lyc_match_ff <= 1'b0;
         mode_ff      <= lcd_tsc_pkg::MODE_HBLANK;
         scy_ff       <= '0;
         scx_ff       <= '0;
         ly_ff        <= '0;
         lyc_ff       <= '0;
         dma_ff       <= '0;
         bgp_ff       <= '0;
         obp0_ff      <= '0;
         obp1_ff      <= '0;
         wy_ff        <= '0;
         wx_ff        <= '0;
         dot_ff       <= '0;
         latch_ff     <= 1'b0;
      end else if (fire) begin
         lcdc_ff      <= lcdc_in;
         stat_en_ff   <= stat_en_in;
         lyc_match_ff <= lyc_match_in;
         mode_ff      <= mode_in;
         scy_ff       <= scy_in;
         scx_ff       <= scx_in;
         ly_ff        <= ly_in;
         lyc_ff       <= lyc_in;
         dma_ff       <= dma_in;
         bgp_ff       <= bgp_in;
         obp0_ff      <= obp0_in;
         obp1_ff      <= obp1_in;
         wy_ff        <= wy_in;
         wx_ff        <= wx_in;
         dot_ff       <= dot_in;
         latch_ff     <= latch_in;
      end
   end

   `LCD_TSC_ASSERT(a_vblank_lines, clock, reset, (ly_ff <= lcd_tsc_pkg::LY_LAST) && ((mode_ff == lcd_tsc_pkg::MODE_VBLANK) == (ly_ff >= lcd_tsc_pkg::LY_VBLANK)), "line number out of step with vblank mode")
   `LCD_TSC_ASSERT_NEXT(a_vblank_entry, clock, reset, fire && rsp.vblank_irq, (mode_ff == lcd_tsc_pkg::MODE_VBLANK) && (ly_ff == lcd_tsc_pkg::LY_VBLANK), "vblank pulse without vblank entry")
   `LCD_TSC_ASSERT_NEXT(a_stat_latch, clock, reset, fire && rsp.stat_irq, latch_ff, "stat pulse left the edge latch clear")
   `LCD_TSC_ASSERT_NEXT(a_lcd_off_tick, clock, reset, fire && (req.cmd == lcd_tsc_pkg::CMD_TICK) && !lcdc_ff[7], (dot_ff == 10'd0) && (ly_ff == 8'd0) && (mode_ff == lcd_tsc_pkg::MODE_HBLANK) && !latch_ff, "tick with display off did not hold timing in reset")

endmodule

FILE: rtl/lcd_timing_stat_controller_core.sv
// Top level of the display timing controller: input and result registers around the sequencer.
//
//   channel | direction | tdata (low bit first)                                | tuser
//   req     | in        | dot_count[6:0] reg_address[22:7] write_data[30:23]   | cmd[1:0]
//   rsp     | out       | read_data[7:0] vblank_irq[8] stat_irq[9]             | -
//           |           | line_done[10] frame_done[11]                         |
//
// One transaction in and one out per clock while rsp is not stalled; a transaction reaches rsp
// after it is taken on req, through the input register and then the result register.
// State changes when a transaction moves from the input register into the result register.
// A stalled rsp holds its result; req keeps taking one more transaction into the input register.
// Synchronous active-high reset returns every display register to zero.
module lcd_timing_stat_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // dot_count, reg_address, write_data, zero pad
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // read_data, vblank_irq, stat_irq, line_done, frame_done, pad
);

   logic                 in_valid_ff, in_valid_in;
   lcd_tsc_pkg::req_type in_data_ff, in_data_in;
   logic                 out_valid_ff, out_valid_in;
   lcd_tsc_pkg::rsp_type out_data_ff;
   lcd_tsc_pkg::rsp_type step_rsp;
   logic                 req_fire;
   logic                 advance;

   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      req_fire     = req_tvalid && req_tready;
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      in_data_in.cmd         = lcd_tsc_pkg::cmd_type'(req_tuser);
      in_data_in.dot_count   = req_tdata[6:0];
      in_data_in.reg_address = req_tdata[22:7];
      in_data_in.write_data  = req_tdata[30:23];
   end

   lcd_tsc_timing u_timing (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_data_ff),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= in_data_in;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_data_ff.frame_done, out_data_ff.line_done,
                        out_data_ff.stat_irq, out_data_ff.vblank_irq, out_data_ff.read_data};

endmodule
